### design/hapseq_pkg.sv
// Shared types, codes and reset constants for the haptic alert sequencer.
`default_nettype none

package hapseq_pkg;

    localparam int CMD_W   = 2;
    localparam int TYPE_W  = 3;
    localparam int TIME_W  = 32;
    localparam int MS_W    = 10;
    localparam int GAP_W   = 16;
    localparam int CNT_W   = 2;
    localparam int FRAME_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

    localparam logic [TYPE_W-1:0] ALERT_MESSAGE  = 3'd0;
    localparam logic [TYPE_W-1:0] ALERT_IDLE     = 3'd1;
    localparam logic [TYPE_W-1:0] ALERT_HR       = 3'd2;
    localparam logic [TYPE_W-1:0] ALERT_STEP     = 3'd3;
    localparam logic [TYPE_W-1:0] ALERT_PACE     = 3'd4;
    localparam logic [TYPE_W-1:0] ALERT_TRAIN_HR = 3'd5;

    localparam logic [FRAME_W-1:0] FRAME_CALL     = 3'd0;
    localparam logic [FRAME_W-1:0] FRAME_MESSAGE  = 3'd1;
    localparam logic [FRAME_W-1:0] FRAME_IDLE     = 3'd2;
    localparam logic [FRAME_W-1:0] FRAME_HR       = 3'd3;
    localparam logic [FRAME_W-1:0] FRAME_STEP     = 3'd4;
    localparam logic [FRAME_W-1:0] FRAME_PACE     = 3'd5;
    localparam logic [FRAME_W-1:0] FRAME_TRAIN_HR = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_OFF_GAP      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REMINDER_GAP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_PULSE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PULSE   = 2'd3;

    localparam logic [MS_W-1:0]  OFF_GAP_RST      = 10'd400;
    localparam logic [GAP_W-1:0] REMINDER_GAP_RST = 16'd2000;
    localparam logic [MS_W-1:0]  SHORT_PULSE_RST  = 10'd40;
    localparam logic [MS_W-1:0]  LONG_PULSE_RST   = 10'd140;

    localparam logic [CNT_W-1:0] CNT_MAX = 2'd3;
    localparam logic [CNT_W-1:0] CNT_TWO = 2'd2;
    localparam logic [CNT_W-1:0] CNT_ONE = 2'd1;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SETUP  = 3'd1,
        PH_ON     = 3'd2,
        PH_OFF    = 3'd3,
        PH_REPEAT = 3'd4,
        PH_GAP    = 3'd5
    } phase_t;

    typedef struct packed {
        logic               valid;
        logic               show;
        logic [CNT_W-1:0]   ppb;
        logic [CNT_W-1:0]   limit;
        logic               long_pulse;
        logic [FRAME_W-1:0] frame;
    } alert_decode_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + CNT_ONE;
    endfunction

endpackage

`default_nettype wire

### design/hapseq_if.sv
// Request, result and configuration channel interfaces of the haptic alert sequencer.
`default_nettype none

interface hapseq_cmd_if;
    import hapseq_pkg::*;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [TYPE_W-1:0] alert_type;
    logic              incoming_call;
    logic              outdoor_run;
    logic              asleep;
    logic              ota_active;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, command, alert_type, incoming_call, outdoor_run,
                    asleep, ota_active, now_ms, input ready);
    modport sink   (input valid, command, alert_type, incoming_call, outdoor_run,
                    asleep, ota_active, now_ms, output ready);
endinterface

interface hapseq_res_if;
    import hapseq_pkg::*;
    logic               valid;
    logic               ready;
    logic               motor_on;
    logic [MS_W-1:0]    pulse_ms;
    logic               display_request;
    logic [FRAME_W-1:0] display_frame;
    logic               busy_res;

    modport source (output valid, motor_on, pulse_ms, display_request, display_frame,
                    busy_res, input ready);
    modport sink   (input valid, motor_on, pulse_ms, display_request, display_frame,
                    busy_res, output ready);
endinterface

interface hapseq_cfg_if;
    import hapseq_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### design/haptic_alert_pattern_sequencer_unit.sv
// Haptic alert sequencer top level: command decode, sequencing state and result register.
//
// Channels: cmd carries one request per item (time step, start or stop alert);
// res returns exactly one result per request; cfg writes the four timing
// registers (index 0 off gap, 1 reminder gap, 2 short pulse, 3 long pulse).
// cfg is always ready and should only be written while no request is pending.
//
// The result register loads at the same edge that takes the request, so
// res.valid is high from the next cycle.
// Throughput: one request per cycle while the result register is empty or drained;
// all the work of one request (decode, a 32-bit add and compare for the gap
// timers, counter updates) is combinational ahead of the result register.
//
// Stalls: cmd.ready is high whenever the result register is empty or is
// being drained in the same cycle, so a stalled receiver holds back at most
// one result and the request side stops only while that result waits.
//
// Reset: rst_n clears the sequencer to idle, motor off, counters at zero,
// and loads the default timing (400, 2000, 40 and 140 ms). No result is valid.
`default_nettype none

module haptic_alert_pattern_sequencer_unit (
    input  wire logic    clk,
    input  wire logic    rst_n,
    hapseq_cmd_if.sink   cmd,
    hapseq_res_if.source res,
    hapseq_cfg_if.sink   cfg
);
    import hapseq_pkg::*;

    // configuration
    logic [MS_W-1:0]  off_gap_reg;
    logic [GAP_W-1:0] reminder_gap_reg;
    logic [MS_W-1:0]  short_pulse_reg;
    logic [MS_W-1:0]  long_pulse_reg;

    // sequencing state
    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  pulse_count_reg, pulse_count_next;
    logic [CNT_W-1:0]  burst_count_reg, burst_count_next;
    logic [CNT_W-1:0]  ppb_reg, ppb_next;
    logic [CNT_W-1:0]  limit_reg, limit_next;
    logic [MS_W-1:0]   pulse_len_reg, pulse_len_next;
    logic [TIME_W-1:0] mark_time_reg, mark_time_next;
    logic              motor_reg, motor_next;

    // result register
    logic               out_valid_reg;
    logic [MS_W-1:0]    out_pulse_reg, out_pulse_next;
    logic               out_req_reg, out_req_next;
    logic [FRAME_W-1:0] out_frame_reg, out_frame_next;

    logic          accept;
    logic          start_ok;
    logic          off_gap_done;
    logic          reminder_done;
    alert_decode_t dec;

    assign cmd.ready = !out_valid_reg || res.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;
    assign start_ok  = (cmd.command == CMD_START) && !cmd.asleep;

    assign off_gap_done  = cmd.now_ms > (mark_time_reg + TIME_W'(off_gap_reg));
    assign reminder_done = cmd.now_ms > (mark_time_reg + TIME_W'(reminder_gap_reg));

    // alert type to burst shape and frame
    always_comb
    begin
        dec = '{valid: 1'b1, show: 1'b1, ppb: CNT_TWO, limit: CNT_ONE,
                long_pulse: 1'b0, frame: FRAME_MESSAGE};
        unique case (cmd.alert_type)
            ALERT_MESSAGE:
            begin
                dec.limit = cmd.incoming_call ? CNT_MAX : CNT_ONE;
                dec.frame = cmd.incoming_call ? FRAME_CALL : FRAME_MESSAGE;
            end
            ALERT_IDLE:
            begin
                dec.limit = CNT_MAX;
                dec.frame = FRAME_IDLE;
            end
            ALERT_HR:
            begin
                dec.ppb   = CNT_MAX;
                dec.limit = CNT_TWO;
                dec.frame = FRAME_HR;
            end
            ALERT_STEP:
            begin
                dec.ppb        = CNT_MAX;
                dec.limit      = CNT_MAX;
                dec.long_pulse = 1'b1;
                dec.frame      = FRAME_STEP;
            end
            ALERT_PACE:
            begin
                dec.long_pulse = 1'b1;
                dec.frame      = FRAME_PACE;
                dec.show       = cmd.outdoor_run;
            end
            ALERT_TRAIN_HR:
            begin
                dec.long_pulse = 1'b1;
                dec.frame      = FRAME_TRAIN_HR;
                dec.show       = cmd.outdoor_run;
            end
            default:
            begin
                dec.valid = 1'b0;
                dec.show  = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        phase_next       = phase_reg;
        pulse_count_next = pulse_count_reg;
        burst_count_next = burst_count_reg;
        ppb_next         = ppb_reg;
        limit_next       = limit_reg;
        pulse_len_next   = pulse_len_reg;
        mark_time_next   = mark_time_reg;
        motor_next       = motor_reg;
        unique case (cmd.command)
            CMD_TICK:
            begin
                if (cmd.ota_active)
                begin
                    phase_next = PH_IDLE;
                    motor_next = 1'b0;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_IDLE:
                        begin
                        end
                        PH_SETUP:
                        begin
                            burst_count_next = '0;
                            phase_next       = PH_ON;
                        end
                        PH_ON:
                        begin
                            mark_time_next = cmd.now_ms;
                            motor_next     = 1'b1;
                            phase_next     = PH_OFF;
                        end
                        PH_OFF:
                        begin
                            motor_next       = 1'b0;
                            mark_time_next   = cmd.now_ms;
                            pulse_count_next = sat_inc(pulse_count_reg);
                            phase_next       = PH_REPEAT;
                        end
                        PH_REPEAT:
                        begin
                            if (off_gap_done)
                            begin
                                if (pulse_count_reg >= ppb_reg)
                                begin
                                    phase_next       = PH_GAP;
                                    burst_count_next = sat_inc(burst_count_reg);
                                    mark_time_next   = cmd.now_ms;
                                end
                                else
                                begin
                                    phase_next = PH_ON;
                                end
                            end
                        end
                        PH_GAP:
                        begin
                            if (reminder_done)
                            begin
                                if (burst_count_reg >= limit_reg)
                                begin
                                    phase_next = PH_IDLE;
                                    motor_next = 1'b0;
                                end
                                else
                                begin
                                    phase_next       = PH_ON;
                                    pulse_count_next = '0;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                            motor_next = 1'b0;
                        end
                    endcase
                end
            end
            CMD_START:
            begin
                if (start_ok)
                begin
                    pulse_count_next = '0;
                    if (dec.valid)
                    begin
                        ppb_next       = dec.ppb;
                        limit_next     = dec.limit;
                        pulse_len_next = dec.long_pulse ? long_pulse_reg : short_pulse_reg;
                        phase_next     = PH_SETUP;
                    end
                end
            end
            CMD_STOP:
            begin
                phase_next = PH_IDLE;
                motor_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // result fields
    always_comb
    begin
        out_pulse_next = '0;
        out_req_next   = 1'b0;
        out_frame_next = FRAME_CALL;
        if ((cmd.command == CMD_TICK) && !cmd.ota_active && (phase_reg == PH_ON))
            out_pulse_next = pulse_len_reg;
        if (start_ok && dec.show)
        begin
            out_req_next   = 1'b1;
            out_frame_next = dec.frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_gap_reg      <= OFF_GAP_RST;
            reminder_gap_reg <= REMINDER_GAP_RST;
            short_pulse_reg  <= SHORT_PULSE_RST;
            long_pulse_reg   <= LONG_PULSE_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_OFF_GAP:      off_gap_reg      <= cfg.data[MS_W-1:0];
                REG_REMINDER_GAP: reminder_gap_reg <= cfg.data[GAP_W-1:0];
                REG_SHORT_PULSE:  short_pulse_reg  <= cfg.data[MS_W-1:0];
                REG_LONG_PULSE:   long_pulse_reg   <= cfg.data[MS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            pulse_count_reg <= '0;
            burst_count_reg <= '0;
            ppb_reg         <= '0;
            limit_reg       <= '0;
            pulse_len_reg   <= '0;
            mark_time_reg   <= '0;
            motor_reg       <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            pulse_count_reg <= pulse_count_next;
            burst_count_reg <= burst_count_next;
            ppb_reg         <= ppb_next;
            limit_reg       <= limit_next;
            pulse_len_reg   <= pulse_len_next;
            mark_time_reg   <= mark_time_next;
            motor_reg       <= motor_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    // payload loads with the state registers, from the pre-request state and the request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_pulse_reg <= out_pulse_next;
            out_req_reg   <= out_req_next;
            out_frame_reg <= out_frame_next;
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.motor_on        = motor_reg;
    assign res.pulse_ms        = out_pulse_reg;
    assign res.display_request = out_req_reg;
    assign res.display_frame   = out_frame_reg;
    assign res.busy_res        = (phase_reg != PH_IDLE);

    // a stop always leaves the sequencer idle with the motor off
    a_stop_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.command == CMD_STOP) |=> (phase_reg == PH_IDLE && !motor_reg))
        else $error("stop request did not force idle");

    // the motor never runs while the sequencer is idle
    a_motor_busy: assert property (@(posedge clk) disable iff (!rst_n)
        motor_reg |-> (phase_reg != PH_IDLE))
        else $error("motor on while idle");

    // a launched pulse drives the motor
    a_pulse_motor: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.pulse_ms != '0) |-> res.motor_on)
        else $error("pulse reported with motor off");

    // a display request only comes with an armed sequence
    a_display_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.display_request) |-> res.busy_res)
        else $error("display request while idle");

    // the state stays put while no request is accepted
    a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> ($stable(phase_reg) && $stable(motor_reg)))
        else $error("state moved without a request");

endmodule

`default_nettype wire
